>>> rtl/core/dwq_pkg.sv
`default_nettype none

package dwq_pkg;

  localparam int COUNT_BITS     = 32;
  localparam int TARGET_BITS    = 16;
  localparam int GAIN_BITS      = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int DRIVE_LIMIT    = 255;
  localparam int DUTY_BITS      = 8;
  localparam int DRIVE_BITS     = $clog2(DRIVE_LIMIT + 1);
  localparam int PROD_BITS      = COUNT_BITS + 2 + GAIN_BITS;
  localparam int SUM_BITS       = PROD_BITS + 2;
  localparam int SHIFT_BITS     = SUM_BITS - GAIN_FRAC_BITS;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_TARGET  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_TARGET = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_P       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_I       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_D       = 3'd4;

  localparam logic [GAIN_BITS-1:0] GAIN_P_RESET = 24'd78643;
  localparam logic [GAIN_BITS-1:0] GAIN_I_RESET = 24'd655;
  localparam logic [GAIN_BITS-1:0] GAIN_D_RESET = 24'd52429;

  localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = 32'sh7fff_ffff;
  localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    STEP_HOLD,
    STEP_UP,
    STEP_DOWN
  } step_t;

  typedef struct packed {
    logic [1:0] func;
    logic       left_a;
    logic       left_b;
    logic       right_a;
    logic       right_b;
  } in_item_t;

  typedef struct packed {
    logic                         left_forward;
    logic                         left_reverse;
    logic [DUTY_BITS-1:0]         left_duty;
    logic                         right_forward;
    logic                         right_reverse;
    logic [DUTY_BITS-1:0]         right_duty;
    logic signed [COUNT_BITS-1:0] left_count;
    logic signed [COUNT_BITS-1:0] right_count;
  } out_item_t;

  // error terms of one wheel for one frame tick
  typedef struct packed {
    logic signed [COUNT_BITS-1:0] err;
    logic signed [COUNT_BITS-1:0] integ;
    logic signed [COUNT_BITS:0]   der;
  } pid_terms_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic out_load;
    logic out_tick;
  } pipe_ctl_t;

  // quadrature transition decode, index is {prev_a, prev_b, a, b}
  function automatic step_t step_lut(input logic [3:0] idx);
    step_t s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_UP;
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_DOWN;
      default:                  s = STEP_HOLD;
    endcase
    return s;
  endfunction

  function automatic logic signed [COUNT_BITS-1:0] sat_count(
    input logic signed [COUNT_BITS:0] v
  );
    logic signed [COUNT_BITS-1:0] r;
    if (v[COUNT_BITS] != v[COUNT_BITS-1]) begin
      r = v[COUNT_BITS] ? COUNT_MIN : COUNT_MAX;
    end else begin
      r = v[COUNT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dwq_wheel.sv
`default_nettype none

module dwq_wheel
  import dwq_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [1:0]                    func,
  input  wire logic                          pin_a,
  input  wire logic                          pin_b,
  input  wire logic signed [TARGET_BITS-1:0] target,
  output pid_terms_t                         terms,
  output logic signed [COUNT_BITS-1:0]       count
);

  logic [1:0]                   prev_ab;
  logic [COUNT_BITS-1:0]        position;
  logic [COUNT_BITS-1:0]        position_next;
  logic [COUNT_BITS-1:0]        frame_delta;
  logic [COUNT_BITS-1:0]        frame_delta_next;
  logic signed [COUNT_BITS-1:0] integral;
  logic signed [COUNT_BITS-1:0] last_error;
  logic [1:0]                   cur_ab;
  step_t                        step;
  pid_terms_t                   terms_next;

  assign cur_ab = {pin_a, pin_b};
  assign step   = step_lut({prev_ab, cur_ab});

  // frame_delta tracks position minus the count at the last frame tick
  always_comb begin
    terms_next.err   = sat_count((COUNT_BITS + 1)'(target)
                                 - (COUNT_BITS + 1)'($signed(frame_delta)));
    terms_next.integ = sat_count((COUNT_BITS + 1)'(integral)
                                 + (COUNT_BITS + 1)'(terms_next.err));
    terms_next.der   = (COUNT_BITS + 1)'(terms_next.err)
                       - (COUNT_BITS + 1)'(last_error);
  end

  always_comb begin
    position_next    = position;
    frame_delta_next = frame_delta;
    unique case (func)
      FUNC_SAMPLE: begin
        if (step == STEP_UP) begin
          position_next    = position + COUNT_BITS'(1);
          frame_delta_next = frame_delta + COUNT_BITS'(1);
        end else if (step == STEP_DOWN) begin
          position_next    = position - COUNT_BITS'(1);
          frame_delta_next = frame_delta - COUNT_BITS'(1);
        end
      end
      FUNC_TICK: begin
        frame_delta_next = '0;
      end
      FUNC_CLEAR: begin
        position_next    = '0;
        frame_delta_next = frame_delta - position;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab     <= '0;
      position    <= '0;
      frame_delta <= '0;
      integral    <= '0;
      last_error  <= '0;
    end else if (load) begin
      position    <= position_next;
      frame_delta <= frame_delta_next;
      if (func == FUNC_SAMPLE) begin
        prev_ab <= cur_ab;
      end
      if (func == FUNC_TICK) begin
        integral   <= terms_next.integ;
        last_error <= terms_next.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms <= terms_next;
      count <= $signed(position_next);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dwq_pid.sv
`default_nettype none

module dwq_pid
  import dwq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pipe_ctl_t            ctl,
  input  wire pid_terms_t           terms,
  input  wire logic [GAIN_BITS-1:0] gain_p,
  input  wire logic [GAIN_BITS-1:0] gain_i,
  input  wire logic [GAIN_BITS-1:0] gain_d,
  output logic                      forward,
  output logic                      reverse,
  output logic [DUTY_BITS-1:0]      duty
);

  logic signed [PROD_BITS-1:0] prod_p;
  logic signed [PROD_BITS-1:0] prod_i;
  logic signed [PROD_BITS-1:0] prod_d;
  logic signed [SUM_BITS-1:0]  sum;
  logic                        neg;
  logic [SUM_BITS-1:0]         mag;
  logic [SHIFT_BITS-1:0]       shifted;
  logic [DRIVE_BITS-1:0]       drive_mag;

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      prod_p <= PROD_BITS'(terms.err)   * PROD_BITS'($signed({1'b0, gain_p}));
      prod_i <= PROD_BITS'(terms.integ) * PROD_BITS'($signed({1'b0, gain_i}));
      prod_d <= PROD_BITS'(terms.der)   * PROD_BITS'($signed({1'b0, gain_d}));
    end
    if (ctl.s3_load) begin
      sum <= SUM_BITS'(prod_p) + SUM_BITS'(prod_i) + SUM_BITS'(prod_d);
    end
  end

  // shift the magnitude so the result truncates toward zero, then clamp
  always_comb begin
    neg     = sum[SUM_BITS-1];
    mag     = neg ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    shifted = mag[SUM_BITS-1:GAIN_FRAC_BITS];
    if (shifted > SHIFT_BITS'(DRIVE_LIMIT)) begin
      drive_mag = DRIVE_BITS'(DRIVE_LIMIT);
    end else begin
      drive_mag = shifted[DRIVE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forward <= 1'b0;
      reverse <= 1'b0;
      duty    <= '0;
    end else if (ctl.out_load && ctl.out_tick) begin
      forward <= !neg && (drive_mag != '0);
      reverse <= neg && (drive_mag != '0);
      duty    <= drive_mag[DUTY_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dual_wheel_quadrature_pid_drive.sv
// Two-wheel encoder counter and speed PID.
//
// Input channel (in_valid / in_stall / in_data): func 0 samples both encoders'
// A/B levels, func 1 is a frame tick that runs the PID of both wheels, func 2
// clears both position counts, func 3 does nothing. Every item gives exactly
// one result on the output channel (out_valid / out_stall / out_data) with the
// drive direction and duty of both wheels and both position counts, all as
// they stand after that item.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
// targets and the Q16 gains; cfg_ready is always high. Write it only while no
// item is in flight.
// out_valid rises once an accepted item has passed the input register, term
// stage, multiplier stage, adder stage and output register, each of which holds
// one item. Throughput is one item per cycle while out_stall is low.
// Reset clears counts, integrators, last errors and drive values, loads the
// default gains and empties the pipeline.
// A stalled result holds in the output register; the stages behind it keep
// filling and in_stall rises only once all of them are occupied.
`default_nettype none

module dual_wheel_quadrature_pid_drive
  import dwq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire in_item_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output out_item_t                    out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [GAIN_BITS-1:0]    cfg_data
);

  logic signed [TARGET_BITS-1:0] left_target;
  logic signed [TARGET_BITS-1:0] right_target;
  logic [GAIN_BITS-1:0]          gain_p;
  logic [GAIN_BITS-1:0]          gain_i;
  logic [GAIN_BITS-1:0]          gain_d;

  in_item_t                     item0;
  logic                         valid0;
  logic                         valid1;
  logic                         valid2;
  logic                         valid3;
  logic                         tick1;
  logic                         tick2;
  logic                         tick3;
  logic signed [COUNT_BITS-1:0] left_count1;
  logic signed [COUNT_BITS-1:0] right_count1;
  logic signed [COUNT_BITS-1:0] left_count2;
  logic signed [COUNT_BITS-1:0] right_count2;
  logic signed [COUNT_BITS-1:0] left_count3;
  logic signed [COUNT_BITS-1:0] right_count3;
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;
  pid_terms_t                   left_terms;
  pid_terms_t                   right_terms;
  logic                         left_forward;
  logic                         left_reverse;
  logic [DUTY_BITS-1:0]         left_duty;
  logic                         right_forward;
  logic                         right_reverse;
  logic [DUTY_BITS-1:0]         right_duty;

  logic      out_ready;
  logic      ready3;
  logic      ready2;
  logic      ready1;
  logic      ready0;
  logic      in_accept;
  pipe_ctl_t ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_target  <= '0;
      right_target <= '0;
      gain_p       <= GAIN_P_RESET;
      gain_i       <= GAIN_I_RESET;
      gain_d       <= GAIN_D_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT_TARGET:  left_target  <= $signed(cfg_data[TARGET_BITS-1:0]);
        REG_RIGHT_TARGET: right_target <= $signed(cfg_data[TARGET_BITS-1:0]);
        REG_GAIN_P:       gain_p       <= cfg_data;
        REG_GAIN_I:       gain_i       <= cfg_data;
        REG_GAIN_D:       gain_d       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a stage advances when it is empty or the stage ahead advances
  assign out_ready = !out_valid || !out_stall;
  assign ready3    = !valid3 || out_ready;
  assign ready2    = !valid2 || ready3;
  assign ready1    = !valid1 || ready2;
  assign ready0    = !valid0 || ready1;
  assign in_stall  = !ready0;
  assign in_accept = in_valid && ready0;

  assign ctl.s1_load  = valid0 && ready1;
  assign ctl.s2_load  = valid1 && ready2;
  assign ctl.s3_load  = valid2 && ready3;
  assign ctl.out_load = valid3 && out_ready;
  assign ctl.out_tick = tick3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0    <= 1'b0;
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      valid3    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        valid0 <= 1'b1;
      end else if (ctl.s1_load) begin
        valid0 <= 1'b0;
      end
      if (ctl.s1_load) begin
        valid1 <= 1'b1;
      end else if (ctl.s2_load) begin
        valid1 <= 1'b0;
      end
      if (ctl.s2_load) begin
        valid2 <= 1'b1;
      end else if (ctl.s3_load) begin
        valid2 <= 1'b0;
      end
      if (ctl.s3_load) begin
        valid3 <= 1'b1;
      end else if (ctl.out_load) begin
        valid3 <= 1'b0;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item0 <= in_data;
    end
    if (ctl.s1_load) begin
      tick1 <= (item0.func == FUNC_TICK);
    end
    if (ctl.s2_load) begin
      tick2        <= tick1;
      left_count2  <= left_count1;
      right_count2 <= right_count1;
    end
    if (ctl.s3_load) begin
      tick3        <= tick2;
      left_count3  <= left_count2;
      right_count3 <= right_count2;
    end
    if (ctl.out_load) begin
      left_count  <= left_count3;
      right_count <= right_count3;
    end
  end

  dwq_wheel u_left_wheel (
    .clk    (clk),
    .rst    (rst),
    .load   (ctl.s1_load),
    .func   (item0.func),
    .pin_a  (item0.left_a),
    .pin_b  (item0.left_b),
    .target (left_target),
    .terms  (left_terms),
    .count  (left_count1)
  );

  dwq_wheel u_right_wheel (
    .clk    (clk),
    .rst    (rst),
    .load   (ctl.s1_load),
    .func   (item0.func),
    .pin_a  (item0.right_a),
    .pin_b  (item0.right_b),
    .target (right_target),
    .terms  (right_terms),
    .count  (right_count1)
  );

  dwq_pid u_left_pid (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .terms   (left_terms),
    .gain_p  (gain_p),
    .gain_i  (gain_i),
    .gain_d  (gain_d),
    .forward (left_forward),
    .reverse (left_reverse),
    .duty    (left_duty)
  );

  dwq_pid u_right_pid (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .terms   (right_terms),
    .gain_p  (gain_p),
    .gain_i  (gain_i),
    .gain_d  (gain_d),
    .forward (right_forward),
    .reverse (right_reverse),
    .duty    (right_duty)
  );

  // drive registers change only when the output register loads
  always_comb begin
    out_data.left_forward  = left_forward;
    out_data.left_reverse  = left_reverse;
    out_data.left_duty     = left_duty;
    out_data.right_forward = right_forward;
    out_data.right_reverse = right_reverse;
    out_data.right_duty    = right_duty;
    out_data.left_count    = left_count;
    out_data.right_count   = right_count;
  end

endmodule

`default_nettype wire

>>> rtl/core/dwq_checker.sv
`default_nettype none

module dwq_checker
  import dwq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a held result stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // pipeline comes out of reset empty
  assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  // one wheel never drives both ways
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.left_forward && out_data.left_reverse)
                  && !(out_data.right_forward && out_data.right_reverse))
    else $error("forward and reverse both set");

  // duty is zero exactly when the wheel is not driven
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.left_duty != '0)
                   == (out_data.left_forward || out_data.left_reverse))
                  && ((out_data.right_duty != '0)
                   == (out_data.right_forward || out_data.right_reverse)))
    else $error("duty and direction disagree");

  // with no result waiting the input is never held off
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |-> !in_stall)
    else $error("input stalled with no result waiting");

endmodule

bind dual_wheel_quadrature_pid_drive dwq_checker u_dwq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
